/* design/htpr_pkg.sv */
// shared types, constants and helpers for the head/tail packet receiver
package htpr_pkg;

	localparam int BYTE_W = 8;
	localparam int PLEN_W = 6;
	localparam int MLEN_W = 3;
	localparam int CNT_W  = 3;
	localparam int POS_W  = 5;
	localparam int DATA_W = 16;
	localparam int ADDR_W = 5;
	localparam int REG_W  = 32;

	localparam logic [2:0] REG_PAYLOAD_LENGTH = 3'd0;
	localparam logic [2:0] REG_FRAME_MODE     = 3'd1;
	localparam logic [2:0] REG_HEADER_LENGTH  = 3'd2;
	localparam logic [2:0] REG_TRAILER_LENGTH = 3'd3;
	localparam logic [2:0] REG_HEADER_BYTES   = 3'd4;
	localparam logic [2:0] REG_TRAILER_BYTES  = 3'd5;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_DROP    = 1'b1;

	localparam logic [PLEN_W-1:0] RST_PAYLOAD_LENGTH = 6'd8;
	localparam logic [MLEN_W-1:0] RST_MARK_LENGTH    = 3'd2;

	typedef struct packed {
		logic [PLEN_W-1:0] payload_length;
		logic              frame_mode;
		logic [MLEN_W-1:0] header_length;
		logic [MLEN_W-1:0] trailer_length;
		logic [REG_W-1:0]  header_bytes;
		logic [REG_W-1:0]  trailer_bytes;
	} cfg_t;

	typedef struct packed {
		logic sel_trailer;
		logic cnt_inc;
		logic cnt_clr;
		logic idx_clr;
		logic store;
		logic emit_start;
		logic rd_en;
		logic load_pay;
		logic load_drop;
		logic emit_next;
	} cmd_t;

	typedef struct packed {
		logic mark_hit;
		logic mark_full;
		logic pay_full;
		logic index_ok;
		logic emit_last;
		logic out_free;
		logic frame_mode;
	} sts_t;

	typedef enum logic [5:0] {
		ST_HUNT    = 6'b000001,
		ST_PAYLOAD = 6'b000010,
		ST_TRAILER = 6'b000100,
		ST_READ    = 6'b001000,
		ST_LOAD    = 6'b010000,
		ST_DROP    = 6'b100000
	} state_t;

	// mark bytes past the register read as zero
	function automatic logic [BYTE_W-1:0] mark_byte(input logic [REG_W-1:0] marks,
		input logic [CNT_W-1:0] pos);
		logic [BYTE_W-1:0] res;
		begin
			case (pos)
				3'd0: res = marks[7:0];
				3'd1: res = marks[15:8];
				3'd2: res = marks[23:16];
				3'd3: res = marks[31:24];
				default: res = '0;
			endcase
			return res;
		end
	endfunction

endpackage

/* design/htpr_ram.sv */
// generic single write port ram with registered read
module htpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/htpr_regs.sv */
// configuration register file behind the apb port
module htpr_regs import htpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.payload_length <= RST_PAYLOAD_LENGTH;
			cfg_q.frame_mode     <= 1'b0;
			cfg_q.header_length  <= RST_MARK_LENGTH;
			cfg_q.trailer_length <= RST_MARK_LENGTH;
			cfg_q.header_bytes   <= '0;
			cfg_q.trailer_bytes  <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PAYLOAD_LENGTH: cfg_q.payload_length <= pwdata[PLEN_W-1:0];
				REG_FRAME_MODE:     cfg_q.frame_mode     <= pwdata[0];
				REG_HEADER_LENGTH:  cfg_q.header_length  <= pwdata[MLEN_W-1:0];
				REG_TRAILER_LENGTH: cfg_q.trailer_length <= pwdata[MLEN_W-1:0];
				REG_HEADER_BYTES:   cfg_q.header_bytes   <= pwdata;
				REG_TRAILER_BYTES:  cfg_q.trailer_bytes  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PAYLOAD_LENGTH: prdata = {{(REG_W-PLEN_W){1'b0}}, cfg_q.payload_length};
			REG_FRAME_MODE:     prdata = {{(REG_W-1){1'b0}}, cfg_q.frame_mode};
			REG_HEADER_LENGTH:  prdata = {{(REG_W-MLEN_W){1'b0}}, cfg_q.header_length};
			REG_TRAILER_LENGTH: prdata = {{(REG_W-MLEN_W){1'b0}}, cfg_q.trailer_length};
			REG_HEADER_BYTES:   prdata = cfg_q.header_bytes;
			REG_TRAILER_BYTES:  prdata = cfg_q.trailer_bytes;
			default:            prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* design/htpr_datapath.sv */
// counters, mark compare, payload store and output register
module htpr_datapath import htpr_pkg::*; #(
	parameter int PAYLOAD_MAX = 32,
	parameter int MARK_MAX    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  cmd_t              cmd,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [DATA_W-1:0] m_tdata,
	output logic              m_tlast,
	output logic              m_tuser,
	output sts_t              sts
);

	localparam int RAM_AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

	logic [CNT_W-1:0]  cnt_q;
	logic [PLEN_W-1:0] idx_q;
	logic [PLEN_W-1:0] emit_q;
	logic [PLEN_W-1:0] plen_q;
	logic              out_valid_q;
	logic              out_kind_q;
	logic              out_last_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [POS_W-1:0]  out_pos_q;

	logic [PLEN_W:0]   plen_ext;
	logic [PLEN_W-1:0] plen;
	logic [MLEN_W:0]   hlen_ext;
	logic [MLEN_W:0]   tlen_ext;
	logic [MLEN_W-1:0] mlen;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [PLEN_W-1:0] idx_nxt;
	logic [PLEN_W-1:0] emit_nxt;
	logic [REG_W-1:0]  marks;
	logic              store_we;
	logic [BYTE_W-1:0] rd_byte;

	// length clamps
	always_comb begin
		plen_ext = {1'b0, cfg.payload_length};
		if (plen_ext == '0) begin
			plen_ext = (PLEN_W+1)'(1);
		end else if (plen_ext > (PLEN_W+1)'(PAYLOAD_MAX)) begin
			plen_ext = (PLEN_W+1)'(PAYLOAD_MAX);
		end
		hlen_ext = {1'b0, cfg.header_length};
		if (hlen_ext == '0) begin
			hlen_ext = (MLEN_W+1)'(1);
		end else if (hlen_ext > (MLEN_W+1)'(MARK_MAX)) begin
			hlen_ext = (MLEN_W+1)'(MARK_MAX);
		end
		tlen_ext = {1'b0, cfg.trailer_length};
		if (tlen_ext == '0) begin
			tlen_ext = (MLEN_W+1)'(1);
		end else if (tlen_ext > (MLEN_W+1)'(MARK_MAX)) begin
			tlen_ext = (MLEN_W+1)'(MARK_MAX);
		end
	end

	assign plen     = plen_ext[PLEN_W-1:0];
	assign mlen     = cmd.sel_trailer ? tlen_ext[MLEN_W-1:0] : hlen_ext[MLEN_W-1:0];
	assign marks    = cmd.sel_trailer ? cfg.trailer_bytes : cfg.header_bytes;
	assign cnt_nxt  = cnt_q + CNT_W'(1);
	assign idx_nxt  = idx_q + PLEN_W'(1);
	assign emit_nxt = emit_q + PLEN_W'(1);
	assign store_we = cmd.store && ({1'b0, idx_q} < (PLEN_W+1)'(PAYLOAD_MAX));

	assign sts.mark_hit   = (rx_byte == mark_byte(marks, cnt_q));
	assign sts.mark_full  = (cnt_nxt >= mlen);
	assign sts.pay_full   = (idx_nxt >= plen);
	assign sts.index_ok   = (idx_q == plen);
	assign sts.emit_last  = (emit_nxt == plen_q);
	assign sts.out_free   = !out_valid_q || m_tready;
	assign sts.frame_mode = cfg.frame_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			emit_q <= '0;
			plen_q <= '0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_nxt;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.store) begin
				idx_q <= idx_nxt;
			end
			if (cmd.emit_start) begin
				emit_q <= '0;
				plen_q <= plen;
			end else if (cmd.emit_next) begin
				emit_q <= emit_nxt;
			end
		end
	end

	htpr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(PAYLOAD_MAX)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(idx_q[RAM_AW-1:0]),
		.wdata(rx_byte),
		.re   (cmd.rd_en),
		.raddr(emit_q[RAM_AW-1:0]),
		.rdata(rd_byte)
	);

	// output register, parts the emitter from the downstream stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_pay || cmd.load_drop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pay) begin
			out_kind_q <= KIND_PAYLOAD;
			out_byte_q <= rd_byte;
			out_pos_q  <= emit_q[POS_W-1:0];
			out_last_q <= sts.emit_last;
		end else if (cmd.load_drop) begin
			out_kind_q <= KIND_DROP;
			out_byte_q <= '0;
			out_pos_q  <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(DATA_W-POS_W-BYTE_W){1'b0}}, out_pos_q, out_byte_q};

endmodule

/* design/htpr_ctrl.sv */
// deframing and emission sequencer
module htpr_ctrl import htpr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   acc;

	assign s_tready = (state_q == ST_HUNT) || (state_q == ST_PAYLOAD) ||
		(state_q == ST_TRAILER);
	assign acc = s_tvalid && s_tready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_HUNT: begin
				if (acc) begin
					if (sts.mark_hit) begin
						cmd.cnt_inc = 1'b1;
						if (sts.mark_full) begin
							cmd.cnt_clr = 1'b1;
							cmd.idx_clr = 1'b1;
							state_nxt   = ST_PAYLOAD;
						end
					end else begin
						cmd.cnt_clr = 1'b1;
					end
				end
			end
			ST_PAYLOAD: begin
				if (acc) begin
					cmd.store = 1'b1;
					if (sts.pay_full) begin
						cmd.cnt_clr = 1'b1;
						if (sts.frame_mode) begin
							state_nxt = ST_TRAILER;
						end else begin
							cmd.idx_clr    = 1'b1;
							cmd.emit_start = 1'b1;
							state_nxt      = ST_READ;
						end
					end
				end
			end
			ST_TRAILER: begin
				cmd.sel_trailer = 1'b1;
				if (acc) begin
					if (sts.mark_hit) begin
						cmd.cnt_inc = 1'b1;
						if (sts.mark_full) begin
							cmd.cnt_clr = 1'b1;
							cmd.idx_clr = 1'b1;
							if (sts.index_ok) begin
								cmd.emit_start = 1'b1;
								state_nxt      = ST_READ;
							end else begin
								state_nxt = ST_DROP;
							end
						end
					end else begin
						cmd.cnt_clr = 1'b1;
						cmd.idx_clr = 1'b1;
						state_nxt   = ST_DROP;
					end
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					cmd.load_pay  = 1'b1;
					cmd.emit_next = 1'b1;
					state_nxt     = sts.emit_last ? ST_HUNT : ST_READ;
				end
			end
			ST_DROP: begin
				if (sts.out_free) begin
					cmd.load_drop = 1'b1;
					state_nxt     = ST_HUNT;
				end
			end
			default: begin
				state_nxt = ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* design/head_tail_packet_receiver_unit.sv */
// top level of the head/tail packet receiver
//
// channel   dir  handshake                  payload
// s_*       in   s_tvalid / s_tready        s_tdata: rx_byte
// m_*       out  m_tvalid / m_tready        m_tdata, m_tlast, m_tuser
// apb       in   psel & penable & pwrite    six registers at 4*i
//
// a byte that completes no packet does not block input; the next byte is taken at once
// a good packet then blocks input while each payload byte gets a registered store read,
// then an output load, and while the output stalls
// a dropped packet blocks input until the output register is free to take the drop result
// reset clears the sequencer, counters and output valid; the payload store is not cleared
// the last result waits in the output register while new bytes are taken
module head_tail_packet_receiver_unit import htpr_pkg::*; #(
	parameter int PAYLOAD_MAX = 32,
	parameter int MARK_MAX    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,  // [7:0] rx_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,  // [7:0] payload_byte, [12:8] byte_position
	output logic              m_tlast,  // last_of_run
	output logic              m_tuser,  // [0] result_kind
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	htpr_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	htpr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	htpr_datapath #(
		.PAYLOAD_MAX(PAYLOAD_MAX),
		.MARK_MAX   (MARK_MAX)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.rx_byte (s_tdata),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser),
		.sts     (sts)
	);

endmodule

/* design/htpr_checker.sv */
// port level checks for the head/tail packet receiver, bound to the top level
module htpr_port_checks import htpr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata,
	input logic              m_tlast,
	input logic              m_tuser
);

	// a drop result stands alone and carries no byte
	a_drop_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_DROP) |-> m_tlast && (m_tdata == '0))
		else $error("drop result not last or not zero");

	// no byte is taken while a packet burst is still being sent
	a_burst_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken during payload burst");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind head_tail_packet_receiver_unit htpr_port_checks u_htpr_port_checks (.*);

/* bench/htpr_checker.sv */
// checker for the head/tail packet receiver: predicts packet results and compares them
module htpr_checker import htpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,
	input  logic              m_tlast,
	input  logic              m_tuser,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output int                mismatches,
	output int                pending
);

	localparam int STORE_DEPTH = 32;
	localparam int MARK_LIMIT  = 4;

	typedef enum logic [1:0] {
		FR_HUNT,
		FR_PAYLOAD,
		FR_TRAILER
	} frame_phase_t;

	typedef struct packed {
		logic              kind;
		logic [POS_W-1:0]  pos;
		logic [BYTE_W-1:0] data;
		logic              last;
	} rx_result_t;

	cfg_t              regs;
	frame_phase_t      fphase;
	int                mcount;
	int                pindex;
	logic [BYTE_W-1:0] store [STORE_DEPTH];
	rx_result_t        due [$];

	function automatic int clamp_len(input int v, input int hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [BYTE_W-1:0] mark_at(input logic [REG_W-1:0] marks, input int i);
		if (i >= MARK_LIMIT) return '0;
		return marks[8*i +: 8];
	endfunction

	task automatic apply_write(input logic [ADDR_W-1:0] addr, input logic [REG_W-1:0] val);
		case (addr[ADDR_W-1:2])
			REG_PAYLOAD_LENGTH: regs.payload_length = val[PLEN_W-1:0];
			REG_FRAME_MODE:     regs.frame_mode     = val[0];
			REG_HEADER_LENGTH:  regs.header_length  = val[MLEN_W-1:0];
			REG_TRAILER_LENGTH: regs.trailer_length = val[MLEN_W-1:0];
			REG_HEADER_BYTES:   regs.header_bytes   = val;
			REG_TRAILER_BYTES:  regs.trailer_bytes  = val;
			default: ;
		endcase
	endtask

	task automatic deframe_byte(input logic [BYTE_W-1:0] b);
		int         plen;
		int         hlen;
		int         tlen;
		int         k;
		bit         done;
		bit         drop;
		rx_result_t r;
		plen = clamp_len(regs.payload_length, STORE_DEPTH);
		hlen = clamp_len(regs.header_length, MARK_LIMIT);
		tlen = clamp_len(regs.trailer_length, MARK_LIMIT);
		done = 0;
		drop = 0;
		case (fphase)
			FR_HUNT: begin
				// a mismatching byte is not retried as a first header byte
				if (b == mark_at(regs.header_bytes, mcount & 7)) begin
					mcount = (mcount + 1) & 7;
					if (mcount >= hlen) begin
						fphase = FR_PAYLOAD;
						mcount = 0;
						pindex = 0;
					end
				end else begin
					mcount = 0;
				end
			end
			FR_PAYLOAD: begin
				if (pindex < STORE_DEPTH) store[pindex] = b;
				pindex = (pindex + 1) & 63;
				if (pindex >= plen) begin
					if (regs.frame_mode) begin
						fphase = FR_TRAILER;
						mcount = 0;
					end else begin
						done = 1;
					end
				end
			end
			default: begin
				if (b == mark_at(regs.trailer_bytes, mcount & 7)) begin
					mcount = (mcount + 1) & 7;
					if (mcount >= tlen) begin
						if (pindex == plen) done = 1;
						else drop = 1;
					end
				end else begin
					drop = 1;
				end
			end
		endcase
		if (done || drop) begin
			fphase = FR_HUNT;
			mcount = 0;
			pindex = 0;
		end
		if (done) begin
			for (k = 0; k < plen; k++) begin
				r.kind = KIND_PAYLOAD;
				r.data = store[k];
				r.pos  = k[POS_W-1:0];
				r.last = (k + 1 == plen);
				due.push_back(r);
			end
		end else if (drop) begin
			r.kind = KIND_DROP;
			r.data = '0;
			r.pos  = '0;
			r.last = 1'b1;
			due.push_back(r);
		end
	endtask

	task automatic compare_result();
		rx_result_t        want;
		logic [DATA_W-1:0] want_tdata;
		if (due.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result at %0t: kind %0d tdata %h last %0d",
					$time, m_tuser, m_tdata, m_tlast);
			mismatches++;
		end else begin
			want = due.pop_front();
			want_tdata = '0;
			want_tdata[BYTE_W-1:0] = want.data;
			want_tdata[BYTE_W +: POS_W] = want.pos;
			if (m_tuser !== want.kind || m_tdata !== want_tdata || m_tlast !== want.last) begin
				if (mismatches < 10)
					$display("bad result at %0t: expected kind %0d tdata %h last %0d, got kind %0d tdata %h last %0d",
						$time, want.kind, want_tdata, want.last, m_tuser, m_tdata, m_tlast);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.payload_length = RST_PAYLOAD_LENGTH;
			regs.frame_mode     = 1'b0;
			regs.header_length  = RST_MARK_LENGTH;
			regs.trailer_length = RST_MARK_LENGTH;
			regs.header_bytes   = '0;
			regs.trailer_bytes  = '0;
			fphase     = FR_HUNT;
			mcount     = 0;
			pindex     = 0;
			due.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
			if (m_tvalid && m_tready) compare_result();
			if (s_tvalid && s_tready) deframe_byte(s_tdata);
			pending = due.size();
		end
	end

endmodule

/* bench/tb_head_tail_packet_receiver_unit.sv */
// testbench top for the head/tail packet receiver: packet stimulus, register setup and verdict
module tb_head_tail_packet_receiver_unit import htpr_pkg::*; ();

	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int HOLD_CYCLES = 300;

	typedef enum int {
		PKT_GOOD,
		PKT_BAD_TRAILER,
		PKT_BAD_HEADER,
		PKT_TRUNCATED,
		PKT_NOISE
	} pkt_kind_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;
	logic              m_tuser;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [REG_W-1:0]  pwdata;
	logic [REG_W-1:0]  prdata;
	logic              pready;

	int   mismatch_count;
	int   results_owed;
	int   sent_count = 0;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	bit   calm = 0;
	bit   hold_request = 0;
	cfg_t cur_cfg;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	head_tail_packet_receiver_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	htpr_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatch_count),
		.pending    (results_owed)
	);

	function automatic int clamped_len(input int v, input int hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	// drain every owed result, then allow the sequencer to come to rest
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (results_owed != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [REG_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PAYLOAD_LENGTH: cur_cfg.payload_length = val[PLEN_W-1:0];
			REG_FRAME_MODE:     cur_cfg.frame_mode     = val[0];
			REG_HEADER_LENGTH:  cur_cfg.header_length  = val[MLEN_W-1:0];
			REG_TRAILER_LENGTH: cur_cfg.trailer_length = val[MLEN_W-1:0];
			REG_HEADER_BYTES:   cur_cfg.header_bytes   = val;
			REG_TRAILER_BYTES:  cur_cfg.trailer_bytes  = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// narrow registers get random junk above their field
	task automatic set_config(input int plen, input int mode, input int hlen, input int tlen,
		input logic [REG_W-1:0] hdr, input logic [REG_W-1:0] trl);
		settle();
		apb_write(REG_PAYLOAD_LENGTH, ($urandom() & ~32'h3F) | plen);
		apb_write(REG_FRAME_MODE, ($urandom() & ~32'h1) | mode);
		apb_write(REG_HEADER_LENGTH, ($urandom() & ~32'h7) | hlen);
		apb_write(REG_TRAILER_LENGTH, ($urandom() & ~32'h7) | tlen);
		apb_write(REG_HEADER_BYTES, hdr);
		apb_write(REG_TRAILER_BYTES, trl);
	endtask

	task automatic send_packet(input pkt_kind_t kind);
		int                hl;
		int                pl;
		int                tl;
		int                cut;
		int                bad_at;
		int                i;
		logic [BYTE_W-1:0] b;
		hl = clamped_len(cur_cfg.header_length, 4);
		pl = clamped_len(cur_cfg.payload_length, 32);
		tl = clamped_len(cur_cfg.trailer_length, 4);
		if (kind == PKT_NOISE) begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			return;
		end
		bad_at = $urandom_range(0, hl - 1);
		for (i = 0; i < hl; i++) begin
			b = cur_cfg.header_bytes[8*i +: 8];
			if (kind == PKT_BAD_HEADER && i == bad_at) b = b ^ 8'($urandom_range(1, 255));
			send_byte(b);
		end
		cut = (kind == PKT_TRUNCATED) ? $urandom_range(0, pl - 1) : pl;
		for (i = 0; i < cut; i++) send_byte(8'($urandom_range(0, 255)));
		if (kind == PKT_TRUNCATED || !cur_cfg.frame_mode) return;
		bad_at = $urandom_range(0, tl - 1);
		for (i = 0; i < tl; i++) begin
			b = cur_cfg.trailer_bytes[8*i +: 8];
			if (kind == PKT_BAD_TRAILER && i == bad_at) b = b ^ 8'($urandom_range(1, 255));
			send_byte(b);
		end
	endtask

	// result receiver: random stall bursts plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 0;
				stall_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (!calm && rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
				stall_left = $urandom_range(0, 17);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int        setting_no;
		int        npkts;
		int        r;
		int        plen;
		pkt_kind_t kind;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		cur_cfg.payload_length = RST_PAYLOAD_LENGTH;
		cur_cfg.frame_mode     = 1'b0;
		cur_cfg.header_length  = RST_MARK_LENGTH;
		cur_cfg.trailer_length = RST_MARK_LENGTH;
		cur_cfg.header_bytes   = '0;
		cur_cfg.trailer_bytes  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		apb_write(REG_SPARE_LO, $urandom());
		apb_write(REG_SPARE_HI, $urandom());
		// zero lengths act as one
		set_config(0, 1, 0, 0, 32'h0000_00FF, 32'h0000_0000);
		send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00);
		send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h01);
		// oversized mark lengths act as four; failed header byte is not retried
		set_config(2, 0, 7, 7, 32'h4433_2211, 32'h0000_0000);
		send_byte(8'h11); send_byte(8'h11); send_byte(8'h22); send_byte(8'h33);
		send_byte(8'h44);
		send_byte(8'h11); send_byte(8'h22); send_byte(8'h33); send_byte(8'h44);
		send_byte(8'hA5); send_byte(8'h5A);
		// header shortened part way through
		send_byte(8'h11); send_byte(8'h22);
		settle();
		apb_write(REG_HEADER_LENGTH, 2);
		send_byte(8'h33); send_byte(8'h3C); send_byte(8'hC3);
		// mode and payload length changed mid packet
		set_config(4, 1, 1, 1, 32'h0000_005A, 32'h0000_00A5);
		send_byte(8'h5A); send_byte(8'h80);
		settle();
		apb_write(REG_FRAME_MODE, 0);
		send_byte(8'h7F);
		settle();
		apb_write(REG_PAYLOAD_LENGTH, 2);
		send_byte(8'h01);
		// payload length changed while the trailer is matched
		settle();
		apb_write(REG_FRAME_MODE, 1);
		send_byte(8'h5A); send_byte(8'h10); send_byte(8'h20);
		settle();
		apb_write(REG_PAYLOAD_LENGTH, 3);
		send_byte(8'hA5);

		// random part, one register setting per round
		setting_no = 0;
		while (sent_count < 440) begin
			case (setting_no)
				0: set_config(32, 1, 4, 4, 32'hFFFF_FFFF, 32'h0000_0000);
				1: set_config(1, 0, 1, 1, 32'h0000_0000, 32'hFFFF_FFFF);
				2: set_config(63, 0, 0, 7, $urandom(), $urandom());
				3: set_config(0, 1, 7, 0, $urandom(), $urandom());
				default: begin
					plen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 63)
						: $urandom_range(0, 6);
					set_config(plen, $urandom_range(0, 1), $urandom_range(0, 7),
						$urandom_range(0, 7), $urandom(), $urandom());
				end
			endcase
			if (sent_count >= 390) calm = 1;
			if (calm) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = 15 * $urandom_range(0, 2);
				rx_idle_pct = 15 * $urandom_range(0, 2);
			end
			if (setting_no == 2) hold_request = 1;
			npkts = (clamped_len(cur_cfg.payload_length, 32) > 16) ? $urandom_range(2, 3)
				: $urandom_range(3, 8);
			repeat (npkts) begin
				r = $urandom_range(0, 99);
				if (r < 65) kind = PKT_GOOD;
				else if (r < 75) kind = PKT_BAD_TRAILER;
				else if (r < 83) kind = PKT_BAD_HEADER;
				else if (r < 91) kind = PKT_TRUNCATED;
				else kind = PKT_NOISE;
				send_packet(kind);
			end
			setting_no++;
		end

		settle();
		if (mismatch_count == 0 && results_owed == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
